// File: design/plru_ts_pkg.sv
`default_nettype none

package plru_ts_pkg;

    localparam int ADDR_W     = 30;
    localparam int LINE_OFF_W = 3;
    localparam int BLOCK_W    = ADDR_W - LINE_OFF_W;
    localparam int NUM_WAYS   = 4;
    localparam int WAY_W      = 2;
    localparam int PLRU_W     = 3;
    localparam int COUNT_W    = 32;

    // reciprocal multiply for the set index, split in two partial products
    localparam int RECIP_W = BLOCK_W + 1;
    localparam int LO_W    = 14;
    localparam int HI_W    = BLOCK_W - LO_W;
    localparam int PROD_W  = BLOCK_W + RECIP_W;

    typedef logic [ADDR_W-1:0]  t_word_addr;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [WAY_W-1:0]   t_way;
    typedef logic [PLRU_W-1:0]  t_plru;
    typedef logic [COUNT_W-1:0] t_count;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // victim way when the whole set is valid, indexed by the tree state
    localparam t_way VICTIM_OF_STATE [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    function automatic t_plru plru_next(input t_plru st, input t_way way);
        t_plru res;
        unique case (way)
            2'd0:    res = {2'b11, st[0]};
            2'd1:    res = {2'b10, st[0]};
            2'd2:    res = {1'b0, st[1], 1'b1};
            default: res = {1'b0, st[1], 1'b0};
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/plru_ts_req_if.sv
`default_nettype none

interface plru_ts_req_if import plru_ts_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       req_type;
    t_word_addr word_address;

    modport source (output valid, req_type, word_address, input ready);
    modport sink (input valid, req_type, word_address, output ready);
endinterface

`default_nettype wire

// File: design/plru_ts_res_if.sv
`default_nettype none

interface plru_ts_res_if import plru_ts_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    t_way   way_used;
    logic   write_back;
    t_count hit_count;
    t_count miss_count;
    t_count writeback_count;

    modport source (
        output valid, hit, way_used, write_back, hit_count, miss_count, writeback_count,
        input  ready
    );
    modport sink (
        input  valid, hit, way_used, write_back, hit_count, miss_count, writeback_count,
        output ready
    );
endinterface

`default_nettype wire

// File: design/plru_ts_ram.sv
`default_nettype none

module plru_ts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/plru_ts_index.sv
`default_nettype none

module plru_ts_index import plru_ts_pkg::*; #(
    parameter int NUM_SETS = 32,
    localparam int SetW = $clog2(NUM_SETS),
    localparam int TagW = $clog2(((1 << BLOCK_W) - 1) / NUM_SETS + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_req_type,
    input  wire t_block          i_block,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_req_type,
    output logic [SetW-1:0]      o_set,
    output logic [TagW-1:0]      o_tag
);

    // q = floor(block / NUM_SETS) exactly, by a rounded-up reciprocal
    localparam int RecipShift = BLOCK_W + SetW;
    localparam longint unsigned RecipFull =
        ((64'd1 << RecipShift) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam logic [RECIP_W-1:0] Recip  = RECIP_W'(RecipFull);
    localparam t_block             NsetsB = BLOCK_W'(NUM_SETS);

    logic                       r_v1, r_v2, r_v3;
    logic                       r_t1, r_t2, r_t3;
    t_block                     r_b1, r_b2, r_b3;
    logic [LO_W+RECIP_W-1:0]    r_pp_lo;
    logic [HI_W+RECIP_W-1:0]    r_pp_hi;
    logic [TagW-1:0]            r_q2, r_q3;
    t_block                     r_qn3;

    logic [LO_W+RECIP_W-1:0]    n_pp_lo;
    logic [HI_W+RECIP_W-1:0]    n_pp_hi;
    logic [PROD_W-1:0]          prod;
    logic [TagW-1:0]            n_q;
    t_block                     n_qn;
    t_block                     rem;
    logic                       rdy1, rdy2, rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign n_pp_lo = i_block[LO_W-1:0] * Recip;
    assign n_pp_hi = i_block[BLOCK_W-1:LO_W] * Recip;
    assign prod    = {r_pp_hi, {LO_W{1'b0}}} + PROD_W'(r_pp_lo);
    assign n_q     = TagW'(prod >> RecipShift);
    assign n_qn    = {{(BLOCK_W-TagW){1'b0}}, r_q2} * NsetsB;
    assign rem     = r_b3 - r_qn3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
        if (rdy1 && i_valid) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_b1    <= i_block;
            r_t1    <= i_req_type;
        end
        if (rdy2 && r_v1) begin
            r_q2 <= n_q;
            r_b2 <= r_b1;
            r_t2 <= r_t1;
        end
        if (rdy3 && r_v2) begin
            r_q3  <= r_q2;
            r_qn3 <= n_qn;
            r_b3  <= r_b2;
            r_t3  <= r_t2;
        end
    end

    assign o_valid    = r_v3;
    assign o_req_type = r_t3;
    assign o_set      = rem[SetW-1:0];
    assign o_tag      = r_q3;

endmodule

`default_nettype wire

// File: design/four_way_plru_cache_tag_store.sv
`default_nettype none

// Tag, state and tree pseudo-LRU store of a 4-way set-associative write-back cache
// with 8-word lines. One access (read or write at a word address) is accepted per
// cycle while the result side does not stall and the RAM clear is done, and each gives
// one result: hit, way used, write-back flag and the running hit, miss and write-back
// counts. Three stages work out set index and tag by reciprocal multiplication (so
// NUM_SETS need not be a power of two), one stage reads the set's row from the RAM,
// compares the four ways and writes the row back, and the last is the result
// register. A back-to-back access to the same set is served from a bypass of the row
// just written. After reset the block clears every row of the set RAM in turn, and
// accepts no access until that is done.
module four_way_plru_cache_tag_store import plru_ts_pkg::*; #(
    parameter int NUM_SETS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    plru_ts_req_if.sink    i_req,
    plru_ts_res_if.source  o_res
);

    localparam int SetW = $clog2(NUM_SETS);
    localparam int TagW = $clog2(((1 << BLOCK_W) - 1) / NUM_SETS + 1);
    // row: {plru, dirty[3:0], valid[3:0], tag3, tag2, tag1, tag0}
    localparam int TagsW  = NUM_WAYS * TagW;
    localparam int RowW   = PLRU_W + 2 * NUM_WAYS + TagsW;
    localparam logic [SetW-1:0] LastSet = SetW'(NUM_SETS - 1);

    logic                idx_ready;
    logic                idx_valid;
    logic                idx_type;
    logic [SetW-1:0]     idx_set;
    logic [TagW-1:0]     idx_tag;

    logic                r_clr_busy;
    logic [SetW-1:0]     r_clr_idx;

    logic                r_l_valid;
    logic                r_l_type;
    logic [SetW-1:0]     r_l_set;
    logic [TagW-1:0]     r_l_tag;
    logic                r_fwd_use;
    logic [RowW-1:0]     r_fwd_row;

    logic                r_o_valid;
    logic                r_o_hit;
    t_way                r_o_way;
    logic                r_o_wb;
    t_count              r_hits;
    t_count              r_misses;
    t_count              r_wbs;

    logic [RowW-1:0]     ram_rdata;
    logic [RowW-1:0]     row;
    logic [RowW-1:0]     n_row;
    logic                ram_we;
    logic [SetW-1:0]     ram_waddr;
    logic [RowW-1:0]     ram_wdata;

    logic                l_adv;
    logic                l_take;
    logic                l_load;
    logic                l_write;

    logic                lk_hit;
    t_way                lk_way;
    logic                lk_wb;

    assign l_adv   = !r_o_valid || o_res.ready;
    assign l_take  = !r_l_valid || l_adv;
    assign l_load  = idx_valid && l_take;
    assign l_write = r_l_valid && l_adv;

    plru_ts_index #(
        .NUM_SETS (NUM_SETS)
    ) u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid && !r_clr_busy),
        .o_ready    (idx_ready),
        .i_req_type (i_req.req_type),
        .i_block    (i_req.word_address[ADDR_W-1:LINE_OFF_W]),
        .o_valid    (idx_valid),
        .i_ready    (l_take),
        .o_req_type (idx_type),
        .o_set      (idx_set),
        .o_tag      (idx_tag)
    );

    assign i_req.ready = idx_ready && !r_clr_busy;

    assign ram_we    = r_clr_busy || l_write;
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_l_set;
    assign ram_wdata = r_clr_busy ? '0 : n_row;

    plru_ts_ram #(
        .WIDTH (RowW),
        .DEPTH (NUM_SETS)
    ) u_sets (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (l_load),
        .i_raddr (idx_set),
        .o_rdata (ram_rdata)
    );

    assign row = r_fwd_use ? r_fwd_row : ram_rdata;

    always_comb begin
        logic [NUM_WAYS-1:0] valid;
        logic [NUM_WAYS-1:0] dirty;
        logic [NUM_WAYS-1:0] match;
        logic [TagsW-1:0]    tags;
        t_plru               st;
        t_way                hit_way;
        t_way                free_way;
        logic                any_free;

        tags  = row[TagsW-1:0];
        valid = row[TagsW +: NUM_WAYS];
        dirty = row[TagsW+NUM_WAYS +: NUM_WAYS];
        st    = row[RowW-1 -: PLRU_W];

        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = valid[w] && (tags[w*TagW +: TagW] == r_l_tag);
        end

        hit_way = 2'd0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end
        free_way = 2'd0;
        any_free = 1'b0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!valid[w]) begin
                free_way = WAY_W'(w);
                any_free = 1'b1;
            end
        end

        lk_hit = |match;
        priority if (lk_hit) begin
            lk_way = hit_way;
        end else if (any_free) begin
            lk_way = free_way;
        end else begin
            lk_way = VICTIM_OF_STATE[st];
        end
        lk_wb = !lk_hit && valid[lk_way] && dirty[lk_way];

        // fill on miss: valid, clean, new tag
        if (!lk_hit) begin
            valid[lk_way]                = 1'b1;
            dirty[lk_way]                = 1'b0;
            tags[lk_way*TagW +: TagW]    = r_l_tag;
        end
        if (r_l_type == REQ_WRITE) begin
            dirty[lk_way] = 1'b1;
        end
        n_row = {plru_next(st, lk_way), dirty, valid, tags};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_l_valid  <= 1'b0;
            r_fwd_use  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_wbs      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LastSet) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (l_take) begin
                r_l_valid <= idx_valid;
            end
            // same set written at the edge its read is taken: bypass the ram
            if (l_load) begin
                r_fwd_use <= l_write && (idx_set == r_l_set);
            end
            if (l_adv) begin
                r_o_valid <= r_l_valid;
            end
            if (l_write) begin
                if (lk_hit) begin
                    r_hits <= r_hits + 1'b1;
                end else begin
                    r_misses <= r_misses + 1'b1;
                end
                if (lk_wb) begin
                    r_wbs <= r_wbs + 1'b1;
                end
            end
        end
        if (l_load) begin
            r_l_type <= idx_type;
            r_l_set  <= idx_set;
            r_l_tag  <= idx_tag;
        end
        if (l_write) begin
            r_fwd_row <= n_row;
            r_o_hit   <= lk_hit;
            r_o_way   <= lk_way;
            r_o_wb    <= lk_wb;
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.hit             = r_o_hit;
    assign o_res.way_used        = r_o_way;
    assign o_res.write_back      = r_o_wb;
    assign o_res.hit_count       = r_hits;
    assign o_res.miss_count      = r_misses;
    assign o_res.writeback_count = r_wbs;

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plru_ts_pkg::*;

    localparam int NUM_SETS     = 32;
    localparam int RANDOM_ITEMS = 730;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 120;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic   hit;
        t_way   way_used;
        logic   write_back;
        t_count hit_count;
        t_count miss_count;
        t_count writeback_count;
    } t_lookup_result;

    typedef struct packed {
        logic           req_type;
        t_word_addr     addr;
        logic           typed;
        t_lookup_result res;
    } t_access_row;

    typedef enum logic [1:0] {SINK_STEADY, SINK_RANDOM, SINK_PATTERN} t_sink_mode;

    // set 0 is filled, hit, then every victim choice of the tree is walked
    localparam t_access_row DIRECTED [21] = '{
        '{REQ_WRITE, 30'h0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd0, 32'd1, 32'd0}},
        '{REQ_WRITE, 30'h0000_0107, 1'b1, '{1'b0, 2'd1, 1'b0, 32'd0, 32'd2, 32'd0}},
        '{REQ_WRITE, 30'h0000_0200, 1'b1, '{1'b0, 2'd2, 1'b0, 32'd0, 32'd3, 32'd0}},
        '{REQ_READ,  30'h0000_0300, 1'b1, '{1'b0, 2'd3, 1'b0, 32'd0, 32'd4, 32'd0}},
        '{REQ_READ,  30'h0000_0005, 1'b1, '{1'b1, 2'd0, 1'b0, 32'd1, 32'd4, 32'd0}},
        '{REQ_READ,  30'h0000_0400, 1'b1, '{1'b0, 2'd2, 1'b1, 32'd1, 32'd5, 32'd1}},
        '{REQ_WRITE, 30'h0000_0500, 1'b1, '{1'b0, 2'd1, 1'b1, 32'd1, 32'd6, 32'd2}},
        '{REQ_READ,  30'h0000_0600, 1'b1, '{1'b0, 2'd3, 1'b0, 32'd1, 32'd7, 32'd2}},
        '{REQ_READ,  30'h0000_0700, 1'b1, '{1'b0, 2'd0, 1'b1, 32'd1, 32'd8, 32'd3}},
        '{REQ_WRITE, 30'h3FFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd1, 32'd9, 32'd3}},
        '{REQ_READ,  30'h3FFF_FFFF, 1'b1, '{1'b1, 2'd0, 1'b0, 32'd2, 32'd9, 32'd3}},
        '{REQ_WRITE, 30'h3FFF_FF00, 1'b0, '0},
        '{REQ_READ,  30'h0000_0505, 1'b0, '0},
        '{REQ_WRITE, 30'h0000_0600, 1'b0, '0},
        '{REQ_READ,  30'h0000_00F8, 1'b0, '0},
        '{REQ_WRITE, 30'h3FFF_FFF8, 1'b0, '0},
        '{REQ_WRITE, 30'h2AAA_AAAA, 1'b0, '0},
        '{REQ_READ,  30'h1555_5555, 1'b0, '0},
        '{REQ_READ,  30'h3FFF_FF00, 1'b0, '0},
        '{REQ_READ,  30'h0000_0100, 1'b0, '0},
        '{REQ_WRITE, 30'h0000_0008, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    plru_ts_req_if req_if ();
    plru_ts_res_if res_if ();

    four_way_plru_cache_tag_store #(.NUM_SETS(NUM_SETS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // own copy of the tag store
    logic   held_valid [NUM_SETS][NUM_WAYS];
    logic   held_dirty [NUM_SETS][NUM_WAYS];
    t_block held_tag   [NUM_SETS][NUM_WAYS];
    t_plru  tree_bits  [NUM_SETS];
    t_count hits_seen;
    t_count misses_seen;
    t_count writebacks_seen;

    t_lookup_result expected_lookups [$];
    int unsigned    mismatch_count = 0;
    int unsigned    burst_left = 0;
    logic           steady_send = 1'b0;
    logic           hold_off_req = 1'b0;

    function automatic t_lookup_result cache_lookup(input logic rw, input t_word_addr addr);
        t_block         blk;
        t_block         tag;
        int unsigned    set_idx;
        t_plru          st;
        t_lookup_result r;
        logic           found;
        blk     = addr[ADDR_W-1:LINE_OFF_W];
        set_idx = blk % NUM_SETS;
        tag     = t_block'(blk / NUM_SETS);
        st      = tree_bits[set_idx];
        r       = '0;
        found   = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && held_valid[set_idx][w] && held_tag[set_idx][w] == tag) begin
                found      = 1'b1;
                r.way_used = t_way'(w);
            end
        end
        if (found) begin
            r.hit     = 1'b1;
            hits_seen = hits_seen + 1'b1;
        end else begin
            misses_seen = misses_seen + 1'b1;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!found && !held_valid[set_idx][w]) begin
                    found      = 1'b1;
                    r.way_used = t_way'(w);
                end
            end
            // full set: top bit of the tree picks the half, the lower bits the way
            if (!found)
                r.way_used = st[2] ? {1'b1, st[0]} : {1'b0, st[1]};
            if (held_valid[set_idx][r.way_used] && held_dirty[set_idx][r.way_used]) begin
                r.write_back    = 1'b1;
                writebacks_seen = writebacks_seen + 1'b1;
            end
            held_valid[set_idx][r.way_used] = 1'b1;
            held_dirty[set_idx][r.way_used] = 1'b0;
            held_tag[set_idx][r.way_used]   = tag;
        end
        tree_bits[set_idx] = r.way_used[1] ? {1'b0, st[1], ~r.way_used[0]}
                                           : {1'b1, ~r.way_used[0], st[0]};
        if (rw == REQ_WRITE)
            held_dirty[set_idx][r.way_used] = 1'b1;
        r.hit_count       = hits_seen;
        r.miss_count      = misses_seen;
        r.writeback_count = writebacks_seen;
        return r;
    endfunction

    // holds the item until taken, then records what it should give
    task automatic offer_access(input logic rw, input t_word_addr addr,
                                input logic typed, input t_lookup_result typed_res);
        t_lookup_result predicted;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= rw;
        req_if.word_address <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = cache_lookup(rw, addr);
        expected_lookups.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (steady_send)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap        = $urandom_range(1, 6);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [21:0]  tag_pool [6];
        logic [4:0]   hot_sets [4];
        logic [4:0]   set_sel;
        logic [21:0]  tag_sel;
        t_word_addr   addr;
        int unsigned  kind;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_READ;
        req_if.word_address = '0;
        for (int s = 0; s < NUM_SETS; s++) begin
            tree_bits[s] = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                held_valid[s][w] = 1'b0;
                held_dirty[s][w] = 1'b0;
                held_tag[s][w]   = '0;
            end
        end
        hits_seen       = '0;
        misses_seen     = '0;
        writebacks_seen = '0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = 22'($urandom);
        hot_sets[0] = 5'd0;
        hot_sets[1] = 5'd31;
        hot_sets[2] = 5'($urandom);
        hot_sets[3] = 5'($urandom);
        set_sel     = hot_sets[0];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            offer_access(DIRECTED[i].req_type, DIRECTED[i].addr,
                         DIRECTED[i].typed, DIRECTED[i].res);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // long output hold-off while items keep coming, then a stretch with no gaps
            if (n == HOLD_AT)
                hold_off_req <= 1'b1;
            steady_send = (n >= HOLD_AT && n < HOLD_AT + 140) || (n >= 500 && n < 560);
            kind = $urandom_range(0, 99);
            if (kind < 90) begin
                // mostly a few busy sets and a small tag pool: hits, fills and evictions
                if (kind < 75) begin
                    if ($urandom_range(0, 3) != 0)
                        set_sel = hot_sets[$urandom_range(0, 3)];
                end else begin
                    set_sel = 5'($urandom);
                end
                tag_sel = tag_pool[$urandom_range(0, 5)];
                addr    = {tag_sel, set_sel, 3'($urandom)};
            end else begin
                addr = t_word_addr'($urandom);
            end
            offer_access($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, addr, 1'b0, '0);
            pace_sender();
        end
        req_if.valid <= 1'b0;

        while (expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned cyc;
        int unsigned hold_left;
        logic        hold_taken;
        logic        rdy;
        res_if.ready = 1'b0;
        mode         = SINK_STEADY;
        cyc          = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 48 == 0)
                mode = t_sink_mode'($urandom_range(0, 2));
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    SINK_STEADY: rdy = 1'b1;
                    SINK_RANDOM: rdy = ($urandom_range(0, 9) < 7);
                    default:     rdy = (cyc % 4 != 3);
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lookup_result got;
        t_lookup_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.hit, res_if.way_used, res_if.write_back,
                    res_if.hit_count, res_if.miss_count, res_if.writeback_count};
            if (expected_lookups.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: hit=%0d way=%0d wb=%0d",
                             $realtime, got.hit, got.way_used, got.write_back);
            end else begin
                want = expected_lookups.pop_front();
                if (got.hit !== want.hit || got.way_used !== want.way_used ||
                    got.write_back !== want.write_back || got.hit_count !== want.hit_count ||
                    got.miss_count !== want.miss_count ||
                    got.writeback_count !== want.writeback_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp hit=%0d way=%0d wb=%0d n=%0d/%0d/%0d",
                                 $realtime, want.hit, want.way_used, want.write_back,
                                 want.hit_count, want.miss_count, want.writeback_count);
                        $display("    got hit=%0d way=%0d wb=%0d n=%0d/%0d/%0d",
                                 got.hit, got.way_used, got.write_back, got.hit_count,
                                 got.miss_count, got.writeback_count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
